@@ rtl/core/lcbf_pkg.sv @@
// Shared types and codes for the line-counting byte FIFO.
`default_nettype none

package lcbf_pkg;

	localparam int unsigned FIELD_W = 13;

	localparam logic [2:0] KIND_WRITE = 3'd0;
	localparam logic [2:0] KIND_READ  = 3'd1;
	localparam logic [2:0] KIND_LINE  = 3'd2;
	localparam logic [2:0] KIND_PEEK  = 3'd3;
	localparam logic [2:0] KIND_CUT   = 3'd4;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	localparam logic [7:0] NEWLINE = 8'd10;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} state_t;

endpackage

`default_nettype wire

@@ rtl/core/line_counting_byte_fifo_top.sv @@
// Line-counting byte FIFO: ring store, head scan, burst buffer and result sequencer.
`default_nettype none

// One command is taken when start is high and busy is low; results come as one-cycle
// strobes that cannot be held off, the last one marked by is_last. After a write the next
// command may follow at once. Read, peek and cut scan the store at one byte per cycle
// through its single read port, a line read scans the whole line the same way, and read,
// peek and line read then deliver their bytes from the burst buffer at one per cycle once
// the scan ends. Commands that find nothing to do answer in the cycle after acceptance.
// No clearing pass follows reset.
module line_counting_byte_fifo_top
	import lcbf_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 4096,
	parameter int unsigned MAX_BURST   = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [2:0]         kind,
	input  wire logic [7:0]         data_byte,
	input  wire logic [FIELD_W-1:0] count,
	output logic                    strobe,
	output logic [7:0]              out_byte,
	output logic                    byte_valid,
	output logic                    is_last,
	output logic [1:0]              status,
	output logic [FIELD_W-1:0]      moved_count,
	output logic [FIELD_W-1:0]      bytes_stored,
	output logic [FIELD_W-1:0]      lines_stored
);

	localparam int unsigned AW = $clog2(QUEUE_DEPTH);
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned WW = (CW > FIELD_W) ? CW : FIELD_W;
	localparam int unsigned KW = $clog2(MAX_BURST + 1);
	localparam int unsigned BW = (MAX_BURST > 1) ? $clog2(MAX_BURST) : 1;

	function automatic logic [AW-1:0] next_index(input logic [AW-1:0] i);
		next_index = (i == AW'(QUEUE_DEPTH - 1)) ? '0 : i + AW'(1);
	endfunction

	logic [7:0]    store_mem [QUEUE_DEPTH];
	logic [7:0]    burst_mem [MAX_BURST];

	state_t        state_q, state_d;
	logic [AW-1:0] head_q, tail_q, pos_q;
	logic [CW-1:0] total_q, lines_q, moved_q;
	logic [CW-1:0] n_q, issue_q, proc_q;
	logic [KW-1:0] cap_q, emit_q, d_q;
	logic [2:0]    kind_q;
	logic [7:0]    store_rd_s1, burst_rd_q;
	logic          rd_valid_s1;
	logic          res_valid_q, res_bv_q, res_last_q;
	logic [1:0]    res_status_q;

	logic          accept, issue, proc_fire, last_proc, emit_last, buf_wr;
	logic          single, go_scan, do_write;
	logic [1:0]    acc_status;
	logic [CW-1:0] acc_moved, acc_n, proc_inc;
	logic [KW-1:0] acc_cap, d_next;
	logic [WW-1:0] cnt_w, total_w, burst_w, k_rp_w, k_cut_w, cap_w;

	assign accept    = start && (state_q == ST_IDLE);
	assign issue     = (state_q == ST_SCAN) && (issue_q < n_q);
	assign proc_fire = (state_q == ST_SCAN) && rd_valid_s1;
	assign proc_inc  = proc_q + CW'(1);
	assign last_proc = proc_fire && ((proc_inc == n_q)
		|| ((kind_q == KIND_LINE) && (store_rd_s1 == NEWLINE)));
	assign buf_wr    = proc_fire && (WW'(proc_q) < WW'(cap_q));
	assign d_next    = (WW'(cap_q) <= WW'(proc_inc)) ? cap_q : KW'(proc_inc);
	assign emit_last = (state_q == ST_EMIT) && ((emit_q + KW'(1)) == d_q);

	assign cnt_w   = WW'(count);
	assign total_w = WW'(total_q);
	assign burst_w = WW'(MAX_BURST);
	assign cap_w   = (cnt_w > burst_w) ? burst_w : cnt_w;
	assign k_rp_w  = (cap_w > total_w) ? total_w : cap_w;
	assign k_cut_w = (cnt_w > total_w) ? total_w : cnt_w;

	always_comb begin
		single     = 1'b0;
		go_scan    = 1'b0;
		do_write   = 1'b0;
		acc_status = STAT_OK;
		acc_moved  = '0;
		acc_n      = '0;
		acc_cap    = '0;
		unique case (kind) inside
			KIND_WRITE: begin
				single = 1'b1;
				if (total_q == CW'(QUEUE_DEPTH)) begin
					acc_status = STAT_FULL;
				end else begin
					do_write  = 1'b1;
					acc_moved = CW'(1);
				end
			end
			KIND_READ, KIND_PEEK: begin
				if (k_rp_w == '0) begin
					single     = 1'b1;
					acc_status = (total_q == '0) ? STAT_EMPTY : STAT_OK;
				end else begin
					go_scan = 1'b1;
					acc_n   = CW'(k_rp_w);
					acc_cap = KW'(k_rp_w);
				end
			end
			KIND_LINE: begin
				if (lines_q == '0) begin
					single     = 1'b1;
					acc_status = STAT_EMPTY;
				end else begin
					go_scan = 1'b1;
					acc_n   = total_q;
					acc_cap = KW'(cap_w);
				end
			end
			KIND_CUT: begin
				if (k_cut_w == '0) begin
					single = 1'b1;
				end else begin
					go_scan = 1'b1;
					acc_n   = CW'(k_cut_w);
				end
			end
			default: begin
				single = 1'b1;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && go_scan) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (last_proc) begin
					state_d = (d_next != '0) ? ST_EMIT : ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (emit_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			tail_q       <= '0;
			total_q      <= '0;
			lines_q      <= '0;
			moved_q      <= '0;
			pos_q        <= '0;
			n_q          <= '0;
			issue_q      <= '0;
			proc_q       <= '0;
			cap_q        <= '0;
			emit_q       <= '0;
			d_q          <= '0;
			kind_q       <= KIND_WRITE;
			rd_valid_s1  <= 1'b0;
			res_valid_q  <= 1'b0;
			res_bv_q     <= 1'b0;
			res_last_q   <= 1'b0;
			res_status_q <= STAT_OK;
		end else begin
			rd_valid_s1 <= issue;
			res_valid_q <= 1'b0;
			if (accept) begin
				kind_q  <= kind;
				pos_q   <= head_q;
				n_q     <= acc_n;
				cap_q   <= acc_cap;
				issue_q <= '0;
				proc_q  <= '0;
				if (single) begin
					res_valid_q  <= 1'b1;
					res_bv_q     <= 1'b0;
					res_last_q   <= 1'b1;
					res_status_q <= acc_status;
					moved_q      <= acc_moved;
				end
				if (do_write) begin
					tail_q  <= next_index(tail_q);
					total_q <= total_q + CW'(1);
					if (data_byte == NEWLINE) begin
						lines_q <= lines_q + CW'(1);
					end
				end
			end
			if (issue) begin
				pos_q   <= next_index(pos_q);
				issue_q <= issue_q + CW'(1);
			end
			if (proc_fire) begin
				proc_q <= proc_inc;
				if (kind_q != KIND_PEEK) begin
					head_q  <= next_index(head_q);
					total_q <= total_q - CW'(1);
					if ((store_rd_s1 == NEWLINE) && (lines_q != '0)) begin
						lines_q <= lines_q - CW'(1);
					end
				end
				if (last_proc) begin
					moved_q <= proc_inc;
					d_q     <= d_next;
					emit_q  <= '0;
					if (d_next == '0) begin
						res_valid_q  <= 1'b1;
						res_bv_q     <= 1'b0;
						res_last_q   <= 1'b1;
						res_status_q <= STAT_OK;
					end
				end
			end
			if (state_q == ST_EMIT) begin
				emit_q       <= emit_q + KW'(1);
				res_valid_q  <= 1'b1;
				res_bv_q     <= 1'b1;
				res_last_q   <= emit_last;
				res_status_q <= STAT_OK;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && do_write) begin
			store_mem[tail_q] <= data_byte;
		end
		if (issue) begin
			store_rd_s1 <= store_mem[pos_q];
		end
	end

	always_ff @(posedge clk) begin
		if (buf_wr) begin
			burst_mem[proc_q[BW-1:0]] <= store_rd_s1;
		end
		if (state_q == ST_EMIT) begin
			burst_rd_q <= burst_mem[emit_q[BW-1:0]];
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign strobe       = res_valid_q;
	assign out_byte     = res_bv_q ? burst_rd_q : 8'd0;
	assign byte_valid   = res_bv_q;
	assign is_last      = res_last_q;
	assign status       = res_status_q;
	assign moved_count  = FIELD_W'(moved_q);
	assign bytes_stored = FIELD_W'(total_q);
	assign lines_stored = FIELD_W'(lines_q);

endmodule

`default_nettype wire
